// ===== rtl/sbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants for the string bubble sorter
// Holds the command passed from the front queue to the back engine.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int MAX_LINES_DEF  = 32;
    localparam int LINE_BYTES_DEF = 128;
    localparam int LINE_INDEX_W   = 5;

    // register index, taken from paddr[2]
    localparam logic REG_SORT_ASC = 1'b0;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_line;
        logic       end_set;
    } sbs_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/string_bubble_sorter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// string_bubble_sorter: top level
// Loads text lines byte by byte, bubble-sorts line indices and streams them.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one byte per request: s_tdata = char_code,
//   s_tuser = last_of_line, s_tlast = last_of_set (also ends the line).
//   Bytes are taken one per cycle while the queue has room, through a
//   two-entry queue into the line store. On set end the engine sorts and
//   streams line indices on the master side: m_tdata[4:0] = line_index,
//   m_tlast = last_in_run, m_tuser = data_dropped. The line store takes
//   no input while sorting or emitting; the queue holds up to two bytes.
//   Each compare walks both lines through two line store read ports,
//   and each result passes the EMIT_RD, EMIT_OUT and EMIT_WAIT states.
//   A stalled receiver holds the current result and freezes the engine.
//   Reset (aresetn low, synchronous) empties the queue, clears the line
//   count and overflow flag, and sets sort_ascending to 1 (APB address 0).
// ----------------------------------------------------------------------------
module string_bubble_sorter
    import sbs_pkg::*;
#(
    parameter int MAX_LINES  = MAX_LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_of_set
    input  wire logic        s_tuser,   // [0] last_of_line
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [4:0] line_index, [7:5] zero
    output logic             m_tlast,   // last_in_run
    output logic             m_tuser,   // [0] data_dropped
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic     asc_reg;
    logic     cmd_valid;
    logic     cmd_ready;
    sbs_cmd_t cmd;
    logic [LINE_INDEX_W-1:0] idx;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SORT_ASC) ? {31'd0, asc_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asc_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SORT_ASC) begin
            asc_reg <= pwdata[0];
        end
    end

    sbs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    sbs_back #(
        .MAX_LINES  (MAX_LINES),
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sort_ascending (asc_reg),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .line_index     (idx),
        .last_in_run    (m_tlast),
        .data_dropped   (m_tuser)
    );

    assign m_tdata = {(8 - LINE_INDEX_W)'(0), idx};

endmodule
`default_nettype wire

// ===== rtl/sbs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_front: input stage and command queue
// Accepts byte requests, folds set end into line end and queues them.
// ----------------------------------------------------------------------------
module sbs_front
    import sbs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic     s_tlast,
    input  wire logic     s_tuser,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output sbs_cmd_t      cmd
);

    sbs_cmd_t   q_reg [2];
    logic       head_reg;
    logic       tail_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;
    sbs_cmd_t   in_cmd;

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[head_reg];
    assign push      = s_tvalid & s_tready;
    assign pop       = cmd_valid & cmd_ready;

    always_comb begin
        in_cmd.char_code = s_tdata;
        in_cmd.end_line  = s_tuser | s_tlast;
        in_cmd.end_set   = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[tail_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                tail_reg <= ~tail_reg;
            end
            if (pop) begin
                head_reg <= ~head_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sbs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_back: line store, bubble sort sequencer and result output
// Stores queued bytes, sorts line indices on set end and emits them.
// ----------------------------------------------------------------------------
module sbs_back
    import sbs_pkg::*;
#(
    parameter int MAX_LINES  = MAX_LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     sort_ascending,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire sbs_cmd_t cmd,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output logic [LINE_INDEX_W-1:0] line_index,
    output logic          last_in_run,
    output logic          data_dropped
);

    localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int PW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int AW = $clog2(MAX_LINES * LINE_BYTES);

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_RD_ORD, S_RD_LEN, S_CMP, S_CHK,
        S_SWAP1, S_SWAP2, S_EMIT_RD, S_EMIT_OUT, S_EMIT_WAIT
    } state_t;

    logic [7:0]    store_mem [MAX_LINES*LINE_BYTES];
    logic [PW-1:0] len_mem   [MAX_LINES];
    logic [LW-1:0] ord_mem   [MAX_LINES];

    state_t        state_reg;
    logic [CW-1:0] lines_reg;
    logic [PW-1:0] pos_reg;
    logic [AW-1:0] base_reg;
    logic          ovf_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [PW-1:0] k_reg;
    logic          m_valid_reg;
    logic [LINE_INDEX_W-1:0] m_index_reg;
    logic          m_last_reg;
    logic          m_drop_reg;

    logic [LW-1:0] ord_a_q, ord_b_q;
    logic [PW-1:0] len_a_q, len_b_q;
    logic [7:0]    byte_a_q, byte_b_q;

    logic          pop;
    logic          room;
    logic          stored;
    logic [PW-1:0] pos_inc;
    logic [CW-1:0] lines_inc;
    logic [PW-1:0] min_len;
    logic [AW-1:0] addr_a, addr_b;
    logic [LW-1:0] ord_rd_a, ord_rd_b;
    logic          ord_we;
    logic [LW-1:0] ord_wa;
    logic [LW-1:0] ord_wd;
    logic          len_gt, len_lt, byte_gt, byte_lt;

    assign cmd_ready = (state_reg == S_LOAD);
    assign pop       = cmd_valid & cmd_ready;
    assign room      = (lines_reg < CW'(MAX_LINES));
    assign stored    = room && (pos_reg < PW'(LINE_BYTES - 1));
    assign pos_inc   = pos_reg + PW'(stored);
    assign lines_inc = lines_reg + CW'(1);
    assign min_len   = (len_a_q < len_b_q) ? len_a_q : len_b_q;
    assign addr_a    = AW'(AW'(ord_a_q) * AW'(LINE_BYTES)) + AW'(k_reg);
    assign addr_b    = AW'(AW'(ord_b_q) * AW'(LINE_BYTES)) + AW'(k_reg);
    assign len_gt    = len_a_q > len_b_q;
    assign len_lt    = len_a_q < len_b_q;
    assign byte_gt   = byte_a_q > byte_b_q;
    assign byte_lt   = byte_a_q < byte_b_q;

    always_comb begin
        ord_rd_a = j_reg[LW-1:0];
        ord_rd_b = LW'(j_reg + CW'(1));
        if (state_reg == S_EMIT_RD) begin
            ord_rd_a = i_reg[LW-1:0];
        end
        ord_we = 1'b0;
        ord_wa = j_reg[LW-1:0];
        ord_wd = ord_b_q;
        case (state_reg)
            S_INIT: begin
                ord_we = 1'b1;
                ord_wa = i_reg[LW-1:0];
                ord_wd = i_reg[LW-1:0];
            end
            S_SWAP1: begin
                ord_we = 1'b1;
            end
            S_SWAP2: begin
                ord_we = 1'b1;
                ord_wa = LW'(j_reg + CW'(1));
                ord_wd = ord_a_q;
            end
            default: ord_we = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (pop && stored) begin
            store_mem[base_reg + AW'(pos_reg)] <= cmd.char_code;
        end
        if (state_reg == S_CMP) begin
            byte_a_q <= store_mem[addr_a];
            byte_b_q <= store_mem[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && room && cmd.end_line) begin
            len_mem[lines_reg[LW-1:0]] <= pos_inc;
        end
        if (state_reg == S_RD_LEN) begin
            len_a_q <= len_mem[ord_a_q];
            len_b_q <= len_mem[ord_b_q];
        end
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            ord_mem[ord_wa] <= ord_wd;
        end
        if (state_reg == S_RD_ORD || state_reg == S_EMIT_RD) begin
            ord_a_q <= ord_mem[ord_rd_a];
            ord_b_q <= ord_mem[ord_rd_b];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            lines_reg   <= '0;
            pos_reg     <= '0;
            base_reg    <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (pop) begin
                        if (!stored) begin
                            ovf_reg <= 1'b1;
                        end
                        pos_reg <= pos_inc;
                        if (cmd.end_line) begin
                            pos_reg <= '0;
                            if (room) begin
                                lines_reg <= lines_inc;
                                base_reg  <= base_reg + AW'(LINE_BYTES);
                            end
                        end
                        if (cmd.end_set) begin
                            i_reg <= '0;
                            j_reg <= '0;
                            if (room) begin
                                state_reg <= S_INIT;
                            end else if (lines_reg != '0) begin
                                state_reg <= S_INIT;
                            end else begin
                                // empty set: nothing to emit, start over
                                ovf_reg  <= 1'b0;
                                base_reg <= '0;
                            end
                        end
                    end
                end
                S_INIT: begin
                    if (i_reg + CW'(1) == lines_reg) begin
                        i_reg     <= '0;
                        state_reg <= (lines_reg < CW'(2)) ? S_EMIT_RD : S_RD_ORD;
                    end else begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                S_RD_ORD: state_reg <= S_RD_LEN;
                S_RD_LEN: begin
                    k_reg     <= '0;
                    state_reg <= S_CMP;
                end
                S_CMP, S_CHK: begin
                    logic decided;
                    logic gt, lt;
                    decided = 1'b0;
                    gt      = 1'b0;
                    lt      = 1'b0;
                    if (state_reg == S_CMP) begin
                        if (k_reg == min_len) begin
                            decided = 1'b1;
                            gt      = len_gt;
                            lt      = len_lt;
                        end else begin
                            state_reg <= S_CHK;
                        end
                    end else if (byte_a_q != byte_b_q) begin
                        decided = 1'b1;
                        gt      = byte_gt;
                        lt      = byte_lt;
                    end else begin
                        k_reg     <= k_reg + PW'(1);
                        state_reg <= S_CMP;
                    end
                    if (decided) begin
                        if (sort_ascending ? gt : lt) begin
                            state_reg <= S_SWAP1;
                        end else if (j_reg + CW'(2) < lines_reg) begin
                            j_reg     <= j_reg + CW'(1);
                            state_reg <= S_RD_ORD;
                        end else begin
                            j_reg <= '0;
                            if (i_reg + CW'(1) < lines_reg) begin
                                i_reg     <= i_reg + CW'(1);
                                state_reg <= S_RD_ORD;
                            end else begin
                                i_reg     <= '0;
                                state_reg <= S_EMIT_RD;
                            end
                        end
                    end
                end
                S_SWAP1: state_reg <= S_SWAP2;
                S_SWAP2: begin
                    if (j_reg + CW'(2) < lines_reg) begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_RD_ORD;
                    end else begin
                        j_reg <= '0;
                        if (i_reg + CW'(1) < lines_reg) begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= S_RD_ORD;
                        end else begin
                            i_reg     <= '0;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                S_EMIT_RD: state_reg <= S_EMIT_OUT;
                S_EMIT_OUT: begin
                    m_valid_reg <= 1'b1;
                    m_index_reg <= LINE_INDEX_W'(ord_a_q);
                    m_last_reg  <= (i_reg + CW'(1) == lines_reg);
                    m_drop_reg  <= ovf_reg;
                    state_reg   <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        if (i_reg + CW'(1) == lines_reg) begin
                            lines_reg <= '0;
                            pos_reg   <= '0;
                            base_reg  <= '0;
                            ovf_reg   <= 1'b0;
                            i_reg     <= '0;
                            state_reg <= S_LOAD;
                        end else begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign line_index   = m_index_reg;
    assign last_in_run  = m_last_reg;
    assign data_dropped = m_drop_reg;

`ifndef SYNTH
    a_no_pop_in_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_LOAD) |-> !pop) else $error("command taken during sort");
    a_lines_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lines_reg <= CW'(MAX_LINES)) else $error("line count overrun");
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PW'(LINE_BYTES - 1)) else $error("byte position overrun");
    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (i_reg < lines_reg)) else $error("emit past line count");
    a_valid_only_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == S_EMIT_WAIT)) else $error("stray result valid");
`endif

endmodule
`default_nettype wire
